// ===== design/bcdb_pkg.sv =====
// Shared types, constants and helpers for the binary to BCD converter with blanking.
// No dependencies; every other design file imports this package.
package bcdb_pkg;

    localparam int ValueW = 27;
    localparam int HalfW  = 14;   // holds 0..9999
    localparam int PairW  = 7;    // holds 0..99
    localparam int DigitW = 4;
    localparam int CodeW  = 5;
    localparam int ByteW  = 8;
    localparam int NumHalves = 2;
    localparam int NumPairs  = 4;
    localparam int NumDigits = 8;

    localparam logic [ValueW-1:0] DecMax    = 27'd99999999;
    localparam logic [ValueW-1:0] MulDiv10k = 27'd109951163; // ceil(2^40 / 10000)
    localparam int                Shift10k  = 40;
    localparam logic [HalfW-1:0]  Dec10k    = 14'd10000;
    localparam logic [HalfW-1:0]  MulDiv100 = 14'd10486;     // ceil(2^20 / 100)
    localparam int                Shift100  = 20;
    localparam logic [HalfW-1:0]  Dec100    = 14'd100;
    localparam logic [CodeW-1:0]  BlankCode = 5'd31;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              blank_pad;
    } item_t;

    typedef struct packed {
        logic [31:0] high_word;
        logic [31:0] low_word;
    } result_t;

    // Per-stage control: item present, blanking requested.
    typedef struct packed {
        logic valid;
        logic pad;
    } ctl_t;

    typedef logic [NumHalves-1:0][HalfW-1:0] halves_t;
    typedef logic [NumPairs-1:0][PairW-1:0]  pairs_t;

    // Tens digit of a value 0..99 by independent threshold compares.
    function automatic logic [DigitW-1:0] tens_of(input logic [PairW-1:0] x);
        logic [DigitW-1:0] t;
        t = '0;
        for (int i = 1; i < 10; i++)
        begin
            if (x >= PairW'(10 * i))
            begin
                t = DigitW'(i);
            end
        end
        return t;
    endfunction

endpackage

// ===== design/bcdb_split.sv =====
// Splits a clamped value 0..99999999 into upper and lower four-digit halves.
// Uses bcdb_pkg; two register stages (reciprocal multiply, then remainder).
module bcdb_split (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bcdb_pkg::ctl_t                     ctl_in,
    input  logic [bcdb_pkg::ValueW-1:0]        value,
    output bcdb_pkg::ctl_t                     ctl_out,
    output bcdb_pkg::halves_t                  halves
);
    import bcdb_pkg::*;

    logic [2*ValueW-1:0] prod;
    logic [HalfW-1:0]    quot_next;
    logic [HalfW-1:0]    quot_reg;
    logic [ValueW-1:0]   value_reg;
    ctl_t                ctl_a_reg;
    logic [ValueW-1:0]   rem_full;
    halves_t             halves_next;
    halves_t             halves_reg;
    ctl_t                ctl_b_reg;

    assign prod      = value * MulDiv10k;
    assign quot_next = prod[Shift10k +: HalfW];

    assign rem_full    = value_reg - (ValueW'(quot_reg) * ValueW'(Dec10k));
    assign halves_next = {quot_reg, rem_full[HalfW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg   <= quot_next;
        value_reg  <= value;
        halves_reg <= halves_next;
    end

    assign ctl_out = ctl_b_reg;
    assign halves  = halves_reg;

endmodule

// ===== design/bcdb_half.sv =====
// Splits each four-digit half into two digit pairs 0..99.
// Uses bcdb_pkg; two register stages (reciprocal multiply, then remainder).
module bcdb_half (
    input  logic              clk,
    input  logic              rst_n,
    input  bcdb_pkg::ctl_t    ctl_in,
    input  bcdb_pkg::halves_t halves,
    output bcdb_pkg::ctl_t    ctl_out,
    output bcdb_pkg::pairs_t  pairs
);
    import bcdb_pkg::*;

    logic [NumHalves-1:0][2*HalfW-1:0] prod;
    logic [NumHalves-1:0][PairW-1:0]   hund_next;
    logic [NumHalves-1:0][PairW-1:0]   hund_reg;
    halves_t                           halves_reg;
    ctl_t                              ctl_a_reg;
    logic [NumHalves-1:0][HalfW-1:0]   rem_full;
    pairs_t                            pairs_next;
    pairs_t                            pairs_reg;
    ctl_t                              ctl_b_reg;

    always_comb
    begin
        for (int h = 0; h < NumHalves; h++)
        begin
            prod[h]      = halves[h] * MulDiv100;
            hund_next[h] = prod[h][Shift100 +: PairW];
            rem_full[h]  = halves_reg[h] - (HalfW'(hund_reg[h]) * Dec100);
            pairs_next[2*h+1] = hund_reg[h];
            pairs_next[2*h]   = rem_full[h][PairW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hund_reg   <= hund_next;
        halves_reg <= halves;
        pairs_reg  <= pairs_next;
    end

    assign ctl_out = ctl_b_reg;
    assign pairs   = pairs_reg;

endmodule

// ===== design/bcdb_pack.sv =====
// Turns digit pairs into eight digit bytes, applies leading-zero blanking,
// and holds the result register. Uses bcdb_pkg.
module bcdb_pack (
    input  logic              clk,
    input  logic              rst_n,
    input  bcdb_pkg::ctl_t    ctl_in,
    input  bcdb_pkg::pairs_t  pairs,
    output logic              done,
    output bcdb_pkg::result_t result
);
    import bcdb_pkg::*;

    logic [NumDigits-1:0][DigitW-1:0] digits;
    logic [NumDigits-1:0]             blank;
    logic [NumDigits-1:0][ByteW-1:0]  bytes;
    logic                             lead;
    result_t                          result_next;
    result_t                          result_reg;
    logic                             done_reg;

    always_comb
    begin
        for (int p = 0; p < NumPairs; p++)
        begin
            digits[2*p+1] = tens_of(pairs[p]);
            digits[2*p]   = DigitW'(pairs[p] - (PairW'(digits[2*p+1]) * PairW'(10)));
        end

        // Blank from the top down until the first nonzero digit; digit 0 always shows.
        lead  = ctl_in.pad;
        blank = '0;
        for (int i = NumDigits - 1; i > 0; i--)
        begin
            if (lead && (digits[i] == '0))
            begin
                blank[i] = 1'b1;
            end
            else
            begin
                lead = 1'b0;
            end
        end

        for (int i = 0; i < NumDigits; i++)
        begin
            bytes[i] = blank[i] ? ByteW'(BlankCode) : ByteW'(digits[i]);
        end

        result_next.high_word = {bytes[7], bytes[6], bytes[5], bytes[4]};
        result_next.low_word  = {bytes[3], bytes[2], bytes[1], bytes[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/binary_to_bcd_blanking.sv =====
// Binary to eight-digit BCD converter with leading-zero blanking, top level.
// Depends on bcdb_pkg, bcdb_split, bcdb_half and bcdb_pack.
//
// Usage:
//   Input channel: drive item (value, blank_pad) and raise start. A transfer
//   happens at each rising edge with start high and busy low. busy is always
//   low here, so a new item may be transferred on every cycle.
//   Result channel: done is high for exactly one cycle with result (high_word,
//   low_word) valid in that cycle; the transfer completes at the edge that
//   ends it. The receiver cannot stall, so results never back up.
//   Path: an accepted item passes the input register, two split stages, two
//   pair stages and the result register, which raises done with the result.
//   Throughput: one item per cycle; results leave in input order.
//   Values above 99999999 are clamped before conversion. With blank_pad set,
//   leading zero digits become code 31, and a zero value shows only digit 0.
//   Reset (rst_n low) clears all valid flags, dropping any items in flight;
//   data registers are not reset and are ignored until refilled.
module binary_to_bcd_blanking (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bcdb_pkg::item_t   item,
    output logic              done,
    output bcdb_pkg::result_t result
);
    import bcdb_pkg::*;

    ctl_t              ctl_in_reg;
    logic [ValueW-1:0] value_next;
    logic [ValueW-1:0] value_reg;
    ctl_t              ctl_split;
    halves_t           halves;
    ctl_t              ctl_half;
    pairs_t            pairs;

    // Never holds off the sender: every stage advances on every cycle.
    assign busy = 1'b0;

    // Clamp oversized values to the largest eight-digit number.
    assign value_next = (item.value > DecMax) ? DecMax : item.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_in_reg <= '0;
        end
        else
        begin
            ctl_in_reg.valid <= start && !busy;
            ctl_in_reg.pad   <= item.blank_pad;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Divide by 10000: upper and lower four-digit halves.
    bcdb_split u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in_reg),
        .value   (value_reg),
        .ctl_out (ctl_split),
        .halves  (halves)
    );

    // Divide each half by 100: four pairs of digits.
    bcdb_half u_half (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_split),
        .halves  (halves),
        .ctl_out (ctl_half),
        .pairs   (pairs)
    );

    // Final digits, blanking and result register.
    bcdb_pack u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_half),
        .pairs  (pairs),
        .done   (done),
        .result (result)
    );

endmodule

// ===== design/bcdb_checker.sv =====
// Port-level checker for binary_to_bcd_blanking, bound to the top level.
// Uses bcdb_pkg for the payload types.
module bcdb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bcdb_pkg::result_t result
);
    import bcdb_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // Every transfer yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("result missing after input transfer");

    // No result without an earlier transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without matching input transfer");

    // The lowest digit is never blanked.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.low_word[7:0] <= 8'd9))
        else $error("lowest digit out of range");

    // The top byte is a digit or the blank code.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.high_word[31:24] <= 8'd9
                  || result.high_word[31:24] == ByteW'(BlankCode)))
        else $error("top digit byte malformed");

endmodule

bind binary_to_bcd_blanking bcdb_checker u_bcdb_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for binary_to_bcd_blanking: directed table, then random values.
// Depends on bcdb_pkg (item_t, result_t, DecMax, BlankCode) and the design sources.
`timescale 1ns / 100ps

module tb;

    import bcdb_pkg::*;

    // Decimal place values and masks used by the digit predictor.
    localparam logic [31:0] TopPlace   = 32'd10000000;
    localparam logic [31:0] SplitPlace = 32'd10000;
    localparam logic [31:0] KeepUpper  = 32'hFFFFFF00;
    localparam logic [7:0]  BlankByte  = {3'b000, BlankCode};
    localparam logic [31:0] AllBlank   = {4{BlankByte}};
    localparam logic [31:0] AllNines   = 32'h09090909;

    localparam int RandomItems = 1150;
    localparam int IdlePercent = 38;
    localparam int CalmFirst   = 400;   // random items in this window never idle
    localparam int CalmLast    = 650;
    localparam int DrainCycles = 12;    // pipeline is six registers deep
    localparam int CycleLimit  = 200000;
    localparam int ReportMax   = 10;

    typedef struct {
        item_t   stim;
        bit      typed;     // expected result is written into the row
        result_t res;
    } table_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    // Side band that travels with item: lets a table row supply its own expectation.
    logic    typed_now;
    result_t typed_res;

    result_t    pending_digits[$];
    table_row_t digit_table[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;

    binary_to_bcd_blanking dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict the eight digit bytes: clamp, peel digits from the top, blank
    // leading zeros, and keep the lowest digit visible when the value is zero.
    function automatic result_t bcd_convert(input item_t it);
        logic [31:0] rest;
        logic [31:0] place;
        logic [31:0] acc;
        logic [31:0] upper;
        logic [7:0]  digit;
        logic        leading;
        result_t     r;
        rest    = (it.value > DecMax) ? 32'(DecMax) : 32'(it.value);
        leading = it.blank_pad;
        place   = TopPlace;
        acc     = '0;
        upper   = '0;
        for (int k = 0; k < NumDigits; k++)
        begin
            digit = 8'(rest / place);
            rest  = rest % place;
            if (leading)
            begin
                if (digit == 8'd0)
                begin
                    digit = BlankByte;
                end
                else
                begin
                    leading = 1'b0;
                end
            end
            acc = {acc[23:0], digit};
            if (place == SplitPlace)
            begin
                upper = acc;
            end
            place = place / 10;
        end
        // Zero with blanking: force digit 0 back to a visible zero.
        if (leading)
        begin
            acc = acc & KeepUpper;
        end
        r.high_word = upper;
        r.low_word  = acc;
        return r;
    endfunction

    function automatic table_row_t make_row(input int unsigned v, input bit pad,
                                            input bit typed, input logic [31:0] hi,
                                            input logic [31:0] lo);
        table_row_t row;
        row.stim.value     = ValueW'(v);
        row.stim.blank_pad = pad;
        row.typed          = typed;
        row.res.high_word  = hi;
        row.res.low_word   = lo;
        return row;
    endfunction

    // Present one item, optionally idle first, and hold it until the transfer.
    task automatic issue_value(input item_t it, input bit typed, input result_t res,
                               input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < IdlePercent)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        item      <= it;
        typed_now <= typed;
        typed_res <= res;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Pick a random value: mostly shaped toward digit boundaries, the rest full range.
    function automatic item_t random_value();
        item_t       it;
        int unsigned width;
        int unsigned top;
        int unsigned place;
        width = $urandom_range(1, 8);
        top   = 1;
        for (int k = 0; k < width; k++)
        begin
            top = top * 10;
        end
        place = top / 10;
        case ($urandom_range(0, 5))
            0, 1:    it.value = ValueW'($urandom);
            2:       it.value = ValueW'($urandom_range(99999900, 100000100));
            3:       it.value = ValueW'($urandom_range(0, top - 1));
            4:       it.value = ValueW'($urandom_range(1, 9) * place);
            default: it.value = ValueW'($urandom_range(0, 20));
        endcase
        it.blank_pad = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Scoreboard: compare every strobe, then queue an expectation on every transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_digits.size() == 0)
                begin
                    if (mismatch_count < ReportMax)
                    begin
                        $display("unexpected result high=%h low=%h", result.high_word,
                                 result.low_word);
                    end
                    mismatch_count++;
                end
                else
                begin
                    result_t want;
                    want = pending_digits.pop_front();
                    if (result.high_word !== want.high_word
                        || result.low_word !== want.low_word)
                    begin
                        if (mismatch_count < ReportMax)
                        begin
                            $display("mismatch: expected high=%h low=%h, got high=%h low=%h",
                                     want.high_word, want.low_word,
                                     result.high_word, result.low_word);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                pending_digits.push_back(typed_now ? typed_res : bcd_convert(item));
            end
        end
    end

    // Watchdog: end the run if the pipeline or the drain loop hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        item_t   it;
        result_t unused;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        typed_now = 1'b0;
        typed_res = '0;
        unused    = '0;

        // Zero, single digits, saturation and the extremes carry typed answers.
        digit_table.push_back(make_row(0,         0, 1, 32'h0,     32'h0));
        digit_table.push_back(make_row(0,         1, 1, AllBlank,  AllBlank & KeepUpper));
        digit_table.push_back(make_row(1,         1, 1, AllBlank,  32'h1F1F1F01));
        digit_table.push_back(make_row(1,         0, 1, 32'h0,     32'h00000001));
        digit_table.push_back(make_row(99999999,  0, 1, AllNines,  AllNines));
        digit_table.push_back(make_row(99999999,  1, 1, AllNines,  AllNines));
        digit_table.push_back(make_row(100000000, 0, 1, AllNines,  AllNines));
        digit_table.push_back(make_row(100000001, 1, 1, AllNines,  AllNines));
        digit_table.push_back(make_row(134217727, 0, 1, AllNines,  AllNines));
        digit_table.push_back(make_row(134217727, 1, 1, AllNines,  AllNines));
        // Digit-count boundaries, the word split, and zeros after the first digit.
        digit_table.push_back(make_row(10,        1, 0, '0, '0));
        digit_table.push_back(make_row(100,       1, 0, '0, '0));
        digit_table.push_back(make_row(9999,      1, 0, '0, '0));
        digit_table.push_back(make_row(10000,     1, 0, '0, '0));
        digit_table.push_back(make_row(10000,     0, 0, '0, '0));
        digit_table.push_back(make_row(9999999,   1, 0, '0, '0));
        digit_table.push_back(make_row(10000000,  1, 0, '0, '0));
        digit_table.push_back(make_row(10000000,  0, 0, '0, '0));
        digit_table.push_back(make_row(1000001,   1, 0, '0, '0));
        digit_table.push_back(make_row(12345678,  1, 0, '0, '0));
        digit_table.push_back(make_row(87654321,  0, 0, '0, '0));
        digit_table.push_back(make_row(99999998,  1, 0, '0, '0));
        digit_table.push_back(make_row(27'h5555555, 0, 0, '0, '0));
        digit_table.push_back(make_row(27'h2AAAAAA, 1, 0, '0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (digit_table[i])
        begin
            issue_value(digit_table[i].stim, digit_table[i].typed, digit_table[i].res, 1'b1);
        end

        for (int n = 0; n < RandomItems; n++)
        begin
            it = random_value();
            issue_value(it, 1'b0, unused, !(n >= CalmFirst && n < CalmLast));
        end
        start     <= 1'b0;
        typed_now <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0 && pending_digits.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bcdb_pkg.sv
design/bcdb_split.sv
design/bcdb_half.sv
design/bcdb_pack.sv
design/binary_to_bcd_blanking.sv
design/bcdb_checker.sv
sim/tb.sv
